// ===== hw/rtl/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbs_pkg: shared types and constants for the tracked box smoother
// Field widths, sequencer states and the shared multiplier request.
// ----------------------------------------------------------------------------
package tbs_pkg;

	localparam int COORD_W    = 15;
	localparam int ID_W       = 16;
	localparam int BOX_W      = 12;
	localparam int SUM_W      = BOX_W + 1;
	localparam int SCALE_W    = 4;
	localparam int PROD_W     = 32;
	localparam int CORNERS_W  = 4 * COORD_W;
	localparam int ENTRY_W    = ID_W + CORNERS_W;
	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_PAD_W  = OUT_DATA_W - CORNERS_W;
	localparam int OUT_USER_W = 2;

	localparam logic [COORD_W-1:0] COORD_MAX   = {COORD_W{1'b1}};
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1);

	// corner order inside an entry, lowest bits first
	localparam logic [1:0] CRN_LEFT   = 2'd0;
	localparam logic [1:0] CRN_TOP    = 2'd1;
	localparam logic [1:0] CRN_RIGHT  = 2'd2;
	localparam logic [1:0] CRN_BOTTOM = 2'd3;

	localparam logic REQ_DETECT = 1'b0;
	localparam logic REQ_EOF    = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SCALE,
		S_DIFF,
		S_RECIP,
		S_BACK,
		S_FIX,
		S_WRITE
	} state_t;

	typedef enum logic [1:0] {
		MUL_SCALE,
		MUL_RECIP,
		MUL_BACK
	} mul_op_t;

	typedef struct packed {
		mul_op_t              op;
		logic [SUM_W-1:0]     sum;
		logic [SCALE_W-1:0]   scale;
		logic [COORD_W-1:0]   mag;
		logic [COORD_W-1:0]   quot;
	} mul_req_t;

endpackage

// ===== hw/rtl/tbs_ram.sv =====
// ----------------------------------------------------------------------------
// tbs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/tbs_mul.sv =====
// ----------------------------------------------------------------------------
// tbs_mul: shared multiplier of the smoother
// Picks operands by operation (scale, reciprocal, back-multiply) and
// registers the product.
// ----------------------------------------------------------------------------
module tbs_mul #(
	parameter int STEP_DIVISOR = 5
) (
	input  logic                          clk,
	input  tbs_pkg::mul_req_t             req,
	output logic [tbs_pkg::PROD_W-1:0]    prod_s1
);
	import tbs_pkg::*;

	localparam int OPND_W = 16;
	// floor(2^15 / divisor): quotient estimate is exact or one low
	localparam logic [OPND_W-1:0] RECIP_M = OPND_W'((1 << COORD_W) / STEP_DIVISOR);
	localparam logic [OPND_W-1:0] DIV_K   = OPND_W'(STEP_DIVISOR);

	logic [OPND_W-1:0] opa;
	logic [OPND_W-1:0] opb;

	always_comb begin
		case (req.op)
			MUL_SCALE: begin
				opa = OPND_W'(req.sum);
				opb = OPND_W'(req.scale);
			end
			MUL_RECIP: begin
				opa = OPND_W'(req.mag);
				opb = RECIP_M;
			end
			MUL_BACK: begin
				opa = OPND_W'(req.quot);
				opb = DIV_K;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// operands widened first so the full product is kept
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(opa) * PROD_W'(opb);
	end

endmodule

// ===== hw/rtl/tracked_box_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// tracked_box_smoother_unit: per-id box smoothing table
// Scales detection boxes, smooths known ids toward the new box, adds new
// ids, and drops ids not seen by the end of a frame.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  s_axis   | in  | tvalid/tready           | tdata: obj_id,box_x,box_y,box_w,box_h
//           |     |                         | tuser: req_type
//  m_axis   | out | tvalid/tready           | tdata: left,top,right,bottom
//           |     |                         | tuser: first_seen,not_stored
//  cfg      | in  | cfg_wr_en (no wait)     | cfg_wr_data: scale
//
// End-of-frame item: no result item.
// Detection: accept, search, corner loop, write. The search walks the entry
// RAM read port one entry a cycle and ends on a hit or after the last entry.
// Corners go through the one shared multiplier: a new id passes the scale
// and diff steps per corner, a known id also reciprocal, back-multiply, fix.
// No item is taken while one is in work; a waiting result holds back only
// the write step.
// Reset clears valid and seen bits and sets scale to 1; the RAM is not
// cleared, entries are read only behind their valid bit.
// ----------------------------------------------------------------------------
module tracked_box_smoother_unit #(
	parameter int TABLE_ENTRIES = 16,
	parameter int STEP_DIVISOR  = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration: scale
	input  logic                               cfg_wr_en,
	input  logic [tbs_pkg::SCALE_W-1:0]        cfg_wr_data,
	// input items
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [15:0] obj_id, [27:16] box_x, [39:28] box_y, [51:40] box_w, [63:52] box_h
	input  logic [tbs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// [0] req_type
	input  logic                               s_axis_tuser,
	// result items
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [14:0] left, [29:15] top, [44:30] right, [59:45] bottom, [63:60] zero
	output logic [tbs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	// [0] first_seen, [1] not_stored
	output logic [tbs_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
	import tbs_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [COORD_W:0] DIV_K    = (COORD_W + 1)'(STEP_DIVISOR);

	state_t state_q, state_d;

	// configuration
	logic [SCALE_W-1:0]       scale_q;

	// latched detection
	logic [ID_W-1:0]          id_q;
	logic [BOX_W-1:0]         bx_q, by_q, bw_q, bh_q;

	// search walk
	logic [IDX_W-1:0]         walk_q;
	logic                     issue_done_q;
	logic                     chk_vld_s1;
	logic [IDX_W-1:0]         chk_idx_s1;
	logic                     hit_q;
	logic [IDX_W-1:0]         slot_q;
	logic                     free_found_q;
	logic [IDX_W-1:0]         free_q;

	// corner loop
	logic [1:0]               crn_q;
	logic [CORNERS_W-1:0]     cur_q;
	logic [CORNERS_W-1:0]     new_q;
	logic                     sign_q;
	logic [COORD_W-1:0]       mag_q;
	logic [COORD_W-1:0]       q0_q;

	// table flags, one per entry
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] seen_q;

	// output register
	logic                     m_valid_q;
	logic [CORNERS_W-1:0]     out_box_q;
	logic                     out_first_q;
	logic                     out_drop_q;

	// combinational
	logic                     in_acc;
	logic                     issue_act;
	logic                     hit_now;
	logic                     last_chk;
	logic                     out_free;
	logic                     ram_we;
	logic [IDX_W-1:0]         wr_slot;
	logic [ENTRY_W-1:0]       rd_data;
	logic [ID_W-1:0]          rd_ident;
	logic [CORNERS_W-1:0]     rd_corners;
	logic [SUM_W-1:0]         crn_sum;
	mul_req_t                 mreq;
	logic [PROD_W-1:0]        prod_s1;
	logic [COORD_W-1:0]       box_sat;
	logic [COORD_W-1:0]       cur_k;
	logic [COORD_W:0]         diff;
	logic [COORD_W:0]         mag_full;
	logic [COORD_W:0]         rem;
	logic [COORD_W-1:0]       q_fix;
	logic [COORD_W-1:0]       smooth;

	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign issue_act     = (state_q == S_SEARCH) && !issue_done_q;

	assign rd_ident   = rd_data[ENTRY_W-1:CORNERS_W];
	assign rd_corners = rd_data[CORNERS_W-1:0];

	// compare stage sees the entry read in the previous cycle
	assign hit_now  = (state_q == S_SEARCH) && chk_vld_s1 &&
	                  valid_q[chk_idx_s1] && (rd_ident == id_q);
	assign last_chk = chk_vld_s1 && (chk_idx_s1 == LAST_IDX);

	assign out_free = !m_valid_q || m_axis_tready;
	assign wr_slot  = hit_q ? slot_q : free_q;
	assign ram_we   = (state_q == S_WRITE) && out_free && (hit_q || free_found_q);

	// detection-image corner before scaling
	always_comb begin
		case (crn_q)
			CRN_LEFT:   crn_sum = {1'b0, bx_q};
			CRN_TOP:    crn_sum = {1'b0, by_q};
			CRN_RIGHT:  crn_sum = {1'b0, bx_q} + {1'b0, bw_q};
			CRN_BOTTOM: crn_sum = {1'b0, by_q} + {1'b0, bh_q};
			default:    crn_sum = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_RECIP: mreq.op = MUL_RECIP;
			S_BACK:  mreq.op = MUL_BACK;
			default: mreq.op = MUL_SCALE;
		endcase
		mreq.sum   = crn_sum;
		mreq.scale = scale_q;
		mreq.mag   = mag_q;
		// reciprocal product shifted down: quotient estimate
		mreq.quot  = prod_s1[2*COORD_W-1:COORD_W];
	end

	tbs_mul #(
		.STEP_DIVISOR(STEP_DIVISOR)
	) u_mul (
		.clk    (clk),
		.req    (mreq),
		.prod_s1(prod_s1)
	);

	tbs_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_entries (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(wr_slot),
		.wr_data({id_q, new_q}),
		.rd_en  (issue_act),
		.rd_addr(walk_q),
		.rd_data(rd_data)
	);

	// scaled corner, saturated
	assign box_sat = (prod_s1[PROD_W-1:COORD_W] != '0) ? COORD_MAX : prod_s1[COORD_W-1:0];
	assign cur_k   = cur_q[crn_q*COORD_W +: COORD_W];

	// signed step toward the new corner, magnitude divided separately
	assign diff     = {1'b0, box_sat} - {1'b0, cur_k};
	assign mag_full = diff[COORD_W] ? ((COORD_W + 1)'(0) - diff) : diff;

	// remainder correction: estimate is exact or one low
	assign rem    = {1'b0, mag_q} - {1'b0, prod_s1[COORD_W-1:0]};
	assign q_fix  = q0_q + COORD_W'(rem >= DIV_K);
	assign smooth = sign_q ? (cur_k - q_fix) : (cur_k + q_fix);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && (s_axis_tuser == REQ_DETECT)) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (hit_now || last_chk) begin
					state_d = S_SCALE;
				end
			end
			S_SCALE: begin
				state_d = S_DIFF;
			end
			S_DIFF: begin
				if (hit_q) begin
					state_d = S_RECIP;
				end else if (crn_q == CRN_BOTTOM) begin
					state_d = S_WRITE;
				end else begin
					state_d = S_SCALE;
				end
			end
			S_RECIP: begin
				state_d = S_BACK;
			end
			S_BACK: begin
				state_d = S_FIX;
			end
			S_FIX: begin
				state_d = (crn_q == CRN_BOTTOM) ? S_WRITE : S_SCALE;
			end
			S_WRITE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= SCALE_RESET;
			walk_q       <= '0;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			crn_q        <= CRN_LEFT;
			valid_q      <= '0;
			seen_q       <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				scale_q <= cfg_wr_data;
			end

			chk_vld_s1 <= issue_act;

			if (in_acc) begin
				if (s_axis_tuser == REQ_EOF) begin
					// drop entries not seen this frame, start a new frame
					valid_q <= valid_q & seen_q;
					seen_q  <= '0;
				end else begin
					walk_q       <= '0;
					issue_done_q <= 1'b0;
					hit_q        <= 1'b0;
					free_found_q <= 1'b0;
					crn_q        <= CRN_LEFT;
				end
			end

			if (issue_act) begin
				walk_q <= walk_q + 1'b1;
				if (walk_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end
				if (!valid_q[walk_q]) begin
					free_found_q <= 1'b1;
				end
			end

			if (hit_now) begin
				hit_q <= 1'b1;
			end

			if (((state_q == S_DIFF) && !hit_q) || (state_q == S_FIX)) begin
				crn_q <= crn_q + 1'b1;
			end

			if (ram_we) begin
				valid_q[wr_slot] <= 1'b1;
				seen_q[wr_slot]  <= 1'b1;
			end

			if ((state_q == S_WRITE) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			id_q <= s_axis_tdata[ID_W-1:0];
			bx_q <= s_axis_tdata[ID_W +: BOX_W];
			by_q <= s_axis_tdata[ID_W + BOX_W +: BOX_W];
			bw_q <= s_axis_tdata[ID_W + 2*BOX_W +: BOX_W];
			bh_q <= s_axis_tdata[ID_W + 3*BOX_W +: BOX_W];
		end

		chk_idx_s1 <= walk_q;

		// lowest free entry: first invalid one the walk passes
		if (issue_act && !valid_q[walk_q] && !free_found_q) begin
			free_q <= walk_q;
		end

		if (hit_now) begin
			slot_q <= chk_idx_s1;
			cur_q  <= rd_corners;
		end

		if (state_q == S_DIFF) begin
			if (hit_q) begin
				sign_q <= diff[COORD_W];
				mag_q  <= mag_full[COORD_W-1:0];
			end else begin
				new_q[crn_q*COORD_W +: COORD_W] <= box_sat;
			end
		end

		if (state_q == S_BACK) begin
			q0_q <= prod_s1[2*COORD_W-1:COORD_W];
		end

		if (state_q == S_FIX) begin
			new_q[crn_q*COORD_W +: COORD_W] <= smooth;
		end

		if ((state_q == S_WRITE) && out_free) begin
			out_box_q   <= new_q;
			out_first_q <= !hit_q;
			out_drop_q  <= !hit_q && !free_found_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_box_q};
	assign m_axis_tuser  = {out_drop_q, out_first_q};

`ifndef NO_ASSERTIONS
	// a seen mark only ever sits on a live entry
	a_seen_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(seen_q & ~valid_q) == '0)
		else $error("seen bit on an invalid entry");

	// a dropped id is always a new id
	a_drop_new: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
		else $error("not_stored without first_seen");

	// results only come out of the write step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == S_WRITE)
		else $error("result raised outside write step");

	// end of frame clears every seen mark
	a_eof_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_axis_tuser == REQ_EOF) |=> seen_q == '0)
		else $error("seen bits left after end of frame");

	// reciprocal estimate is at most one low
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIX |-> rem < (DIV_K << 1))
		else $error("quotient estimate out of range");
`endif

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for tracked_box_smoother_unit
// Drives detections and end-of-frame items over the input stream. It tracks
// the id table and smoothed corners on its own and compares every result
// item field by field. Senders and receivers stall at random but in the
// last phase, and the scale is changed between phases while the unit is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int TABLE_ENTRIES = 16;
	localparam int STEP_DIVISOR  = 5;
	// leave margin after the last result before cfg writes
	localparam int SETTLE_CYCLES = TABLE_ENTRIES + 40;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS   = 255;

	typedef struct packed {
		logic [tbs_pkg::COORD_W-1:0] left;
		logic [tbs_pkg::COORD_W-1:0] top;
		logic [tbs_pkg::COORD_W-1:0] right;
		logic [tbs_pkg::COORD_W-1:0] bottom;
		logic                        first_seen;
		logic                        not_stored;
	} drawn_box_t;

	// id table copy plus the queue of boxes the unit still owes us
	class box_tracker;
		logic [tbs_pkg::SCALE_W-1:0] scale;
		bit                          live[TABLE_ENTRIES];
		bit                          seen[TABLE_ENTRIES];
		logic [tbs_pkg::ID_W-1:0]    ident[TABLE_ENTRIES];
		int                          corner[TABLE_ENTRIES][4];
		drawn_box_t                  pending_boxes[$];
		int                          mismatch_count;

		function new();
			scale = tbs_pkg::SCALE_RESET;
			foreach (live[i]) begin
				live[i] = 1'b0;
				seen[i] = 1'b0;
			end
			mismatch_count = 0;
		endfunction

		function void set_scale(input logic [tbs_pkg::SCALE_W-1:0] value);
			scale = value;
		endfunction

		function int scaled(input int coord);
			int prod;
			prod = coord * int'(scale);
			return (prod > int'(tbs_pkg::COORD_MAX)) ? int'(tbs_pkg::COORD_MAX) : prod;
		endfunction

		// signed step toward target, int division truncates toward zero
		function int approach(input int cur, input int target);
			return (cur + (target - cur) / STEP_DIVISOR) & int'(tbs_pkg::COORD_MAX);
		endfunction

		function void take_request(input logic req, input logic [tbs_pkg::IN_DATA_W-1:0] data);
			logic [tbs_pkg::ID_W-1:0] id;
			int                       fresh[4];
			int                       drawn[4];
			int                       hit;
			int                       slot;
			drawn_box_t               want;
			if (req == tbs_pkg::REQ_EOF) begin
				foreach (live[i]) begin
					if (live[i] && !seen[i])
						live[i] = 1'b0;
					seen[i] = 1'b0;
				end
				return;
			end
			id       = data[15:0];
			fresh[0] = scaled(int'(data[27:16]));
			fresh[1] = scaled(int'(data[39:28]));
			fresh[2] = scaled(int'(data[27:16]) + int'(data[51:40]));
			fresh[3] = scaled(int'(data[39:28]) + int'(data[63:52]));
			hit  = -1;
			slot = -1;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				if (live[i]) begin
					if (hit < 0 && ident[i] == id)
						hit = i;
				end else if (slot < 0) begin
					slot = i;
				end
			end
			want.first_seen = 1'b0;
			want.not_stored = 1'b0;
			if (hit >= 0) begin
				for (int k = 0; k < 4; k++) begin
					corner[hit][k] = approach(corner[hit][k], fresh[k]);
					drawn[k] = corner[hit][k];
				end
				seen[hit] = 1'b1;
			end else begin
				want.first_seen = 1'b1;
				drawn = fresh;
				if (slot >= 0) begin
					live[slot]   = 1'b1;
					seen[slot]   = 1'b1;
					ident[slot]  = id;
					corner[slot] = fresh;
				end else begin
					want.not_stored = 1'b1;
				end
			end
			want.left   = drawn[0][tbs_pkg::COORD_W-1:0];
			want.top    = drawn[1][tbs_pkg::COORD_W-1:0];
			want.right  = drawn[2][tbs_pkg::COORD_W-1:0];
			want.bottom = drawn[3][tbs_pkg::COORD_W-1:0];
			pending_boxes.push_back(want);
		endfunction

		function void compare(input string name, input logic [31:0] want, input logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_box(input logic [tbs_pkg::OUT_DATA_W-1:0] data,
		                        input logic [tbs_pkg::OUT_USER_W-1:0] user);
			drawn_box_t want;
			if (pending_boxes.size() == 0) begin
				$error("result item with no detection pending: tdata %h", data);
				mismatch_count++;
				return;
			end
			want = pending_boxes.pop_front();
			compare("left",       want.left,       data[14:0]);
			compare("top",        want.top,        data[29:15]);
			compare("right",      want.right,      data[44:30]);
			compare("bottom",     want.bottom,     data[59:45]);
			compare("pad",        0,               data[63:60]);
			compare("first_seen", want.first_seen, user[0]);
			compare("not_stored", want.not_stored, user[1]);
		endfunction
	endclass

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [tbs_pkg::SCALE_W-1:0]      cfg_wr_data;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	// [15:0] obj_id, [27:16] box_x, [39:28] box_y, [51:40] box_w, [63:52] box_h
	logic [tbs_pkg::IN_DATA_W-1:0]    s_axis_tdata;
	// [0] req_type
	logic                             s_axis_tuser;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	// [14:0] left, [29:15] top, [44:30] right, [59:45] bottom, [63:60] zero
	logic [tbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
	// [0] first_seen, [1] not_stored
	logic [tbs_pkg::OUT_USER_W-1:0]   m_axis_tuser;

	bit         bursts_on = 1'b1;
	box_tracker book;

	tracked_box_smoother_unit #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.STEP_DIVISOR (STEP_DIVISOR)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// valid stays high between back-to-back items; only a gap lowers it
	task automatic push_item(input logic req, input logic [tbs_pkg::IN_DATA_W-1:0] data);
		@(negedge clk);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = data;
		s_axis_tuser  = req;
		do
			@(posedge clk);
		while (!s_axis_tready);
		book.take_request(req, data);
	endtask

	task automatic send_detect(input logic [15:0] id, input logic [11:0] x, input logic [11:0] y,
	                           input logic [11:0] w, input logic [11:0] h);
		push_item(tbs_pkg::REQ_DETECT, {h, w, y, x, id});
	endtask

	task automatic send_frame_end(input logic [tbs_pkg::IN_DATA_W-1:0] junk);
		push_item(tbs_pkg::REQ_EOF, junk);
	endtask

	// drain: all boxes back, then let a trailing frame end finish
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (book.pending_boxes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(input logic [tbs_pkg::SCALE_W-1:0] value);
		@(negedge clk);
		cfg_wr_en   = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
		book.set_scale(value);
	endtask

	// frames of detections drawn mostly from a small id pool, so ids repeat
	// across frames and the table fills up now and then
	task automatic run_frames(input int count);
		logic [15:0] pool[20];
		logic [15:0] id;
		logic [11:0] f[4];
		int          sent;
		int          frame_len;
		foreach (pool[k])
			pool[k] = 16'($urandom);
		sent = 0;
		while (sent < count) begin
			frame_len = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 28) : $urandom_range(0, 10);
			for (int j = 0; j < frame_len && sent < count; j++) begin
				id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pool[$urandom_range(0, 19)];
				foreach (f[k]) begin
					if ($urandom_range(0, 7) == 0)
						f[k] = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
					else
						f[k] = 12'($urandom);
				end
				send_detect(id, f[0], f[1], f[2], f[3]);
				sent++;
			end
			send_frame_end({$urandom, $urandom});
			sent++;
		end
	endtask

	task automatic run_directed();
		// saturation, then smoothing down and back up with uneven steps
		send_detect(16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		send_detect(16'hFFFF, 12'd0, 12'd0, 12'd0, 12'd0);
		send_detect(16'hFFFF, 12'd5, 12'd3, 12'd0, 12'd1);
		send_detect(16'h0000, 12'd0, 12'd0, 12'd0, 12'd0);
		// both seen: frame end keeps them, its fields are ignored
		send_frame_end('1);
		// repeat of one id only; the other drops at the next frame end
		send_detect(16'h0000, 12'hFFF, 12'd0, 12'd0, 12'hFFF);
		send_frame_end('0);
		send_frame_end({$urandom, $urandom});
		// fill every entry, then one id too many, then a hit on a full table
		for (int i = 1; i <= TABLE_ENTRIES; i++)
			send_detect(16'(i), 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
		send_detect(16'h8000, 12'd100, 12'd200, 12'd300, 12'd400);
		send_detect(16'h0001, 12'd7, 12'd9, 12'd11, 12'd13);
		send_frame_end({$urandom, $urandom});
	endtask

	// result side: random stall bursts, sampled at the rising edge
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (bursts_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			m_axis_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			book.check_box(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		int phase_scale[RANDOM_PHASES];
		phase_scale   = '{1, 15, 0, 9, 3, 12, 8};
		book          = new();
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = tbs_pkg::REQ_DETECT;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		write_scale(4'd8);
		run_directed();
		settle();

		// scale sweeps the legal ends and the out-of-range codes; last phase runs flat out
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == RANDOM_PHASES - 1) begin
				bursts_on      = 1'b0;
				phase_scale[p] = $urandom_range(1, 8);
			end
			write_scale(tbs_pkg::SCALE_W'(phase_scale[p]));
			run_frames(PHASE_ITEMS);
			settle();
		end

		if (book.mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
